// ===== rtl/core/i2csb_pkg.sv =====
// Package: shared constants, request codes and payload types of the I2C slave buffer engine.
`default_nettype none

package i2csb_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [3:0] CMD_ADDR_WR  = 4'd0;
    localparam logic [3:0] CMD_DATA_RX  = 4'd1;
    localparam logic [3:0] CMD_STOP     = 4'd2;
    localparam logic [3:0] CMD_ADDR_RD  = 4'd3;
    localparam logic [3:0] CMD_SENT_ACK = 4'd4;
    localparam logic [3:0] CMD_SENT_END = 4'd5;
    localparam logic [3:0] CMD_BUS_ERR  = 4'd6;
    localparam logic [3:0] CMD_POP      = 4'd7;
    localparam logic [3:0] CMD_PUSH     = 4'd8;
    localparam logic [3:0] CMD_FLUSH    = 4'd9;

    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_RX    = 2'd1;
    localparam logic [1:0] MODE_TX    = 2'd2;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] data_in;
    } t_in_req;

    typedef struct packed {
        logic [7:0] data_out;
        logic       ok;
        logic [1:0] mode;
        logic [5:0] available;
    } t_out_rsp;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
    } t_dp_cmd;

    typedef struct packed {
        logic need_read;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/i2csb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module i2csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/i2csb_ctrl.sv =====
// Controller state machine: request acceptance, execute, fetch and result handshake.
`default_nettype none

module i2csb_ctrl
    import i2csb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.need_read ? S_FETCH : S_OUT;
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2csb_dpath.sv =====
// Datapath: buffer pointers, bus mode, receive and transmit stores, result register.
`default_nettype none

module i2csb_dpath
    import i2csb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in_req i_in_req,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    output t_out_rsp     o_out_rsp
);

    logic [3:0]       r_cmd;
    logic [7:0]       r_data;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [CNT_W-1:0] r_rx_pos,   n_rx_pos;
    logic [CNT_W-1:0] r_tx_count, n_tx_count;
    logic [CNT_W-1:0] r_tx_pos,   n_tx_pos;
    logic [1:0]       r_mode,     n_mode;
    logic [7:0]       r_dout,     n_dout;
    logic             r_ok,       n_ok;
    logic             r_rd_rx,    n_rd_rx;
    logic             n_rd_tx;

    logic              rx_we, tx_we;
    logic [ADDR_W-1:0] tx_raddr;
    logic [7:0]        rx_rdata, tx_rdata;
    logic [CNT_W-1:0]  avail;

    i2csb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_count[ADDR_W-1:0]),
        .i_wdata (r_data),
        .i_raddr (r_rx_pos[ADDR_W-1:0]),
        .o_rdata (rx_rdata)
    );

    i2csb_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_count[ADDR_W-1:0]),
        .i_wdata (r_data),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    always_comb begin
        n_rx_count = r_rx_count;
        n_rx_pos   = r_rx_pos;
        n_tx_count = r_tx_count;
        n_tx_pos   = r_tx_pos;
        n_mode     = r_mode;
        n_dout     = 8'd0;
        n_ok       = 1'b1;
        n_rd_rx    = 1'b0;
        n_rd_tx    = 1'b0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        tx_raddr   = r_tx_pos[ADDR_W-1:0];
        case (r_cmd)
            CMD_ADDR_WR: begin
                n_mode     = MODE_RX;
                n_rx_count = '0;
                n_rx_pos   = '0;
            end
            CMD_DATA_RX: begin
                if (r_rx_count < CNT_W'(BUF_DEPTH)) begin
                    rx_we      = i_cmd.exec;
                    n_rx_count = r_rx_count + 1'b1;
                end
            end
            CMD_STOP, CMD_SENT_END, CMD_BUS_ERR: begin
                n_mode = MODE_READY;
            end
            CMD_ADDR_RD: begin
                n_mode   = MODE_TX;
                tx_raddr = '0;
                if (r_tx_count != '0) begin
                    n_rd_tx  = 1'b1;
                    n_tx_pos = CNT_W'(1);
                end else begin
                    n_tx_pos = '0;
                    n_dout   = IDLE_BYTE;
                end
            end
            CMD_SENT_ACK: begin
                if (r_tx_pos < r_tx_count) begin
                    n_rd_tx  = 1'b1;
                    n_tx_pos = r_tx_pos + 1'b1;
                end else begin
                    n_dout = IDLE_BYTE;
                end
            end
            CMD_POP: begin
                if (r_rx_pos < r_rx_count) begin
                    n_rd_rx  = 1'b1;
                    n_rx_pos = r_rx_pos + 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            CMD_PUSH: begin
                if (r_tx_count < CNT_W'(BUF_DEPTH)) begin
                    tx_we      = i_cmd.exec;
                    n_tx_count = r_tx_count + 1'b1;
                end else begin
                    n_ok = 1'b0;
                end
            end
            CMD_FLUSH: begin
                n_rx_count = '0;
                n_rx_pos   = '0;
                n_tx_count = '0;
                n_tx_pos   = '0;
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= '0;
            r_rx_pos   <= '0;
            r_tx_count <= '0;
            r_tx_pos   <= '0;
            r_mode     <= MODE_READY;
        end else if (i_cmd.exec) begin
            r_rx_count <= n_rx_count;
            r_rx_pos   <= n_rx_pos;
            r_tx_count <= n_tx_count;
            r_tx_pos   <= n_tx_pos;
            r_mode     <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_req.cmd;
            r_data <= i_in_req.data_in;
        end
        if (i_cmd.exec) begin
            r_dout  <= n_dout;
            r_ok    <= n_ok;
            r_rd_rx <= n_rd_rx;
        end else if (i_cmd.fetch) begin
            r_dout <= r_rd_rx ? rx_rdata : tx_rdata;
        end
    end

    assign avail = r_rx_count - r_rx_pos;

    assign o_sts.need_read = n_rd_rx | n_rd_tx;

    assign o_out_rsp.data_out  = r_dout;
    assign o_out_rsp.ok        = r_ok;
    assign o_out_rsp.mode      = r_mode;
    assign o_out_rsp.available = 6'(avail);

endmodule

`default_nettype wire

// ===== rtl/core/i2c_slave_buffer_engine.sv =====
// Top level of the I2C slave receive/transmit buffer engine.
// Takes one classified bus event or host request at a time and returns one result for each.
// A request is taken only while the engine is idle; it then spends an execute step, plus
// a store read step for a transmit byte or a host pop that finds data, and the result is
// held on o_out_rsp until taken. The store read uses the registered read port of the
// 32-entry stores. The next request is taken in the cycle after the result is taken, so
// the engine takes no new request until the result of the last one is taken. No clearing
// pass after reset.
`default_nettype none

module i2c_slave_buffer_engine
    import i2csb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_in_req i_in_req,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_rsp     o_out_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    i2csb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    i2csb_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_req  (i_in_req),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_out_rsp (o_out_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/i2csb_chk.sv =====
// Port-level checker for the I2C slave buffer engine, with its bind to the top level.
`default_nettype none

module i2csb_chk
    import i2csb_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_out_rsp o_out_rsp
);

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && !o_out_valid))
        else $error("engine not busy after a request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("result dropped or changed while stalled");

    a_rsp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.mode != 2'd3 &&
                         o_out_rsp.available <= 6'(BUF_DEPTH)))
        else $error("result mode or available count out of range");

endmodule

bind i2c_slave_buffer_engine i2csb_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire
